### hdl/cal_pkg.sv
// Shared types, codes and sizes for the cursor array list.
// No dependencies; imported by every other file in hdl.
package cal_pkg;

  localparam int CAPACITY   = 128;
  localparam int ELEM_WIDTH = 8;

  // Field widths at the ports
  localparam int MODE_W = 4;
  localparam int VAL_W  = 8;
  localparam int TGT_W  = 7;
  localparam int STS_W  = 2;
  localparam int LEN_W  = 8;

  // Count and cursor span 0 .. CAPACITY
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > TGT_W) ? CNT_W : TGT_W;

  // Read tree grouping
  localparam int GRP_SIZE = 16;
  localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  typedef logic [ELEM_WIDTH-1:0] elem_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 4'd1;
  localparam logic [MODE_W-1:0] MODE_APPEND = 4'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 4'd3;
  localparam logic [MODE_W-1:0] MODE_START  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_END    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_PREV   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_SEEK   = 4'd8;
  localparam logic [MODE_W-1:0] MODE_SET    = 4'd9;
  localparam logic [MODE_W-1:0] MODE_READ   = 4'd10;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL   = 2'd1;
  localparam logic [STS_W-1:0] STS_NOELEM = 2'd2;
  localparam logic [STS_W-1:0] STS_RANGE  = 2'd3;

  // Cell actions
  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_INS  = 3'd1;
  localparam logic [2:0] ACT_APP  = 3'd2;
  localparam logic [2:0] ACT_REM  = 3'd3;
  localparam logic [2:0] ACT_SET  = 3'd4;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic [2:0] act;
    cnt_t       pos;
    cnt_t       cnt;
    elem_t      val;
  } cell_cmd_t;

endpackage

### hdl/cursor_array_list.sv
// Top level of the cursor array list: controller, chain of cells and read tree.
// Depends on cal_pkg, cal_cell and cal_rd_tree.
//
//   channel | direction | ports                                      | handshake
//   in      | input     | in_mode, in_item_value, in_target_position | in_valid / in_stall
//   out     | output    | out_status, out_list_length,               | out_valid / out_stall
//           |           | out_cursor_position, out_result_value,     |
//           |           | out_value_valid                            |
//
// One transaction at a time: accept, update the cells in EXEC (all elements shift
// in the same cycle), then RD1 and RD2 through the read tree, whose group level is
// registered, for the element under the cursor; the result lands in the output
// register when RD2 finishes, and only then is the next transaction taken.
// Reset empties the list and puts the cursor at 0; cell contents are left as is.
// A stalled result holds the output register; the next transaction still runs and
// waits in its last stage until the output register frees up.
module cursor_array_list (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cal_pkg::MODE_W-1:0]    in_mode,
  input  logic [cal_pkg::VAL_W-1:0]     in_item_value,
  input  logic [cal_pkg::TGT_W-1:0]     in_target_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cal_pkg::STS_W-1:0]     out_status,
  output logic [cal_pkg::LEN_W-1:0]     out_list_length,
  output logic [cal_pkg::LEN_W-1:0]     out_cursor_position,
  output logic [cal_pkg::VAL_W-1:0]     out_result_value,
  output logic                          out_value_valid
);
  import cal_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RD1  = 2'd2;
  localparam logic [1:0] S_RD2  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;
  elem_t             val_r;
  logic [TGT_W-1:0]  tgt_r;
  cnt_t              count_r, count_nxt;
  cnt_t              cursor_r, cursor_nxt;
  logic [STS_W-1:0]  status_r, status_nxt;
  logic              removed_r, removed_nxt;
  logic [2:0]        act;
  cell_cmd_t         cmd;
  elem_t             elems [CAPACITY];
  elem_t             rd_value;
  logic              cap_en;
  logic              fin;
  logic              vld;
  logic              full;
  logic              noelem;

  logic              out_valid_r;
  logic [STS_W-1:0]  out_status_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [LEN_W-1:0]  out_cur_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_vv_r;

  assign in_stall = (state_r != S_IDLE);
  assign fin      = (state_r == S_RD2) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  if (fin) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the transaction
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      mode_r <= in_mode;
      val_r  <= ELEM_WIDTH'(in_item_value);
      tgt_r  <= in_target_position;
    end
  end

  assign full   = (count_r >= CNT_W'(CAPACITY));
  assign noelem = (cursor_r >= count_r);

  always_comb begin
    status_nxt  = STS_OK;
    count_nxt   = count_r;
    cursor_nxt  = cursor_r;
    removed_nxt = 1'b0;
    act         = ACT_NONE;
    unique case (mode_r)
      MODE_CLEAR: begin
        count_nxt  = '0;
        cursor_nxt = '0;
      end
      MODE_INSERT: begin
        if (full) begin
          status_nxt = STS_FULL;
        end else begin
          act       = ACT_INS;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_APPEND: begin
        if (full) begin
          status_nxt = STS_FULL;
        end else begin
          act       = ACT_APP;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (noelem) begin
          status_nxt = STS_NOELEM;
        end else begin
          act         = ACT_REM;
          count_nxt   = count_r - 1'b1;
          removed_nxt = 1'b1;
        end
      end
      MODE_START: cursor_nxt = '0;
      MODE_END:   cursor_nxt = count_r;
      MODE_PREV: begin
        if (cursor_r != '0) cursor_nxt = cursor_r - 1'b1;
      end
      MODE_NEXT: begin
        if (cursor_r < count_r) cursor_nxt = cursor_r + 1'b1;
      end
      MODE_SEEK: begin
        if (CMP_W'(tgt_r) < CMP_W'(count_r)) begin
          cursor_nxt = CNT_W'(tgt_r);
        end else begin
          status_nxt = STS_RANGE;
        end
      end
      MODE_SET: begin
        if (noelem) begin
          status_nxt = STS_NOELEM;
        end else begin
          act = ACT_SET;
        end
      end
      MODE_READ: begin
        if (noelem) status_nxt = STS_NOELEM;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      cursor_r  <= '0;
      status_r  <= STS_OK;
      removed_r <= 1'b0;
    end else if (state_r == S_EXEC) begin
      count_r   <= count_nxt;
      cursor_r  <= cursor_nxt;
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
    end
  end

  assign cmd.act = (state_r == S_EXEC) ? act : ACT_NONE;
  assign cmd.pos = cursor_r;
  assign cmd.cnt = count_r;
  assign cmd.val = val_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    elem_t left_e;
    elem_t right_e;
    if (i == 0) begin : g_first
      assign left_e = elems[i];
    end else begin : g_left
      assign left_e = elems[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = elems[i];
    end else begin : g_right
      assign right_e = elems[i+1];
    end
    cal_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_idx   (CNT_W'(i)),
      .left_elem  (left_e),
      .right_elem (right_e),
      .elem       (elems[i])
    );
  end

  // In EXEC the tree sees the old cells and cursor (the element a remove takes out);
  // in RD1 it sees the updated ones, unless a remove must keep what it captured.
  assign cap_en = (state_r == S_EXEC) || (state_r == S_RD1 && !removed_r);

  cal_rd_tree u_rd_tree (
    .clk      (clk),
    .cap_en   (cap_en),
    .rd_idx   (cursor_r),
    .elems    (elems),
    .rd_value (rd_value)
  );

  assign vld = removed_r || (cursor_r < count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_status_r <= status_r;
      out_len_r    <= LEN_W'(count_r);
      out_cur_r    <= LEN_W'(cursor_r);
      out_val_r    <= vld ? VAL_W'(rd_value) : '0;
      out_vv_r     <= vld;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_list_length     = out_len_r;
  assign out_cursor_position = out_cur_r;
  assign out_result_value    = out_val_r;
  assign out_value_valid     = out_vv_r;

  a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("cursor beyond list length");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_state_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXEC) |=> (count_r == $past(count_r) && cursor_r == $past(cursor_r)))
    else $error("list state changed outside execute");

  a_remove_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD2 && removed_r) |-> (status_r == STS_OK && vld))
    else $error("remove result without element");

endmodule

### hdl/cal_cell.sv
// One storage cell of the list chain: holds one element and shifts with its neighbors.
// Depends on cal_pkg.
module cal_cell (
  input  logic                clk,
  input  cal_pkg::cell_cmd_t  cmd,
  input  cal_pkg::cnt_t       cell_idx,
  input  cal_pkg::elem_t      left_elem,
  input  cal_pkg::elem_t      right_elem,
  output cal_pkg::elem_t      elem
);
  import cal_pkg::*;

  elem_t elem_r;
  elem_t elem_nxt;

  always_comb begin
    elem_nxt = elem_r;
    case (cmd.act)
      ACT_INS: begin
        if (cell_idx == cmd.pos) begin
          elem_nxt = cmd.val;
        end else if (cell_idx > cmd.pos) begin
          elem_nxt = left_elem;
        end
      end
      ACT_APP: begin
        if (cell_idx == cmd.cnt) begin
          elem_nxt = cmd.val;
        end
      end
      ACT_REM: begin
        // close the gap: everything from the cursor up takes its right neighbor
        if (cell_idx >= cmd.pos) begin
          elem_nxt = right_elem;
        end
      end
      ACT_SET: begin
        if (cell_idx == cmd.pos) begin
          elem_nxt = cmd.val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  assign elem = elem_r;

endmodule

### hdl/cal_rd_tree.sv
// Two-level read tree that picks the element at one index out of the cell chain.
// Depends on cal_pkg; the group level is registered, the final OR is combinational.
module cal_rd_tree (
  input  logic            clk,
  input  logic            cap_en,
  input  cal_pkg::cnt_t   rd_idx,
  input  cal_pkg::elem_t  elems [cal_pkg::CAPACITY],
  output cal_pkg::elem_t  rd_value
);
  import cal_pkg::*;

  elem_t grp_r   [NGRP];
  elem_t grp_nxt [NGRP];

  always_comb begin
    int idx;
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        idx = g * GRP_SIZE + j;
        if (idx < CAPACITY) begin
          if (CNT_W'(idx) == rd_idx) begin
            grp_nxt[g] = grp_nxt[g] | elems[idx];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap_en) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_comb begin
    rd_value = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_value = rd_value | grp_r[g];
    end
  end

endmodule
